// ===== rtl/core/bounded_priority_task_dispatcher_unit_defines.svh =====
`ifndef BOUNDED_PRIORITY_TASK_DISPATCHER_UNIT_DEFINES_SVH
`define BOUNDED_PRIORITY_TASK_DISPATCHER_UNIT_DEFINES_SVH

// Property that must hold in the same cycle as its condition.
`define BPTD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Property that must hold in the cycle after its condition.
`define BPTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/bptd_pkg.sv =====
package bptd_pkg;

   typedef enum logic [2:0] {
      CMD_SUBMIT       = 3'd0,
      CMD_PROCESS      = 3'd1,
      CMD_TICK         = 3'd2,
      CMD_SET_FOCUS    = 3'd3,
      CMD_CLEAR_SWITCH = 3'd4,
      CMD_CLEAR_ALL    = 3'd5
   } cmd_type;

   localparam logic [2:0] KIND_REHEARSAL  = 3'd0;
   localparam logic [2:0] KIND_ENCODING   = 3'd1;
   localparam logic [2:0] KIND_RETRIEVAL  = 3'd2;
   localparam logic [2:0] KIND_INHIBITION = 3'd3;
   localparam logic [2:0] KIND_SWITCHING  = 3'd4;

   localparam logic [2:0] FOCUS_NONE = 3'd0;
   localparam logic [2:0] FOCUS_PHON = 3'd1;
   localparam logic [2:0] FOCUS_VISU = 3'd2;
   localparam logic [2:0] FOCUS_EPIS = 3'd3;
   localparam logic [2:0] FOCUS_DIV  = 3'd4;

   localparam logic [16:0] AGE_MAX     = 17'h1FFFF;
   localparam logic [15:0] SWITCH_MAX  = 16'hFFFF;
   localparam logic [3:0]  LIMIT_RESET = 4'd10;
   localparam logic [15:0] SPAN_RESET  = 16'd2000;

   localparam logic CSR_TASK_LIMIT = 1'b0;
   localparam logic CSR_FOCUS_SPAN = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_EVICT,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_INSERT,
      OP_POP,
      OP_EVICT,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      logic              valid;
      logic [2:0]        kind;
      logic signed [7:0] prio;
      logic [2:0]        tgt;
   } entry_type;

   typedef struct packed {
      op_type            op;
      entry_type         item;
      logic signed [7:0] key;
   } chain_ctrl_type;

   typedef struct packed {
      logic [2:0]        cmd;
      logic [2:0]        task_kind;
      logic signed [7:0] task_priority;
      logic [2:0]        target_focus;
   } req_payload_type;

   typedef struct packed {
      logic              did_process;
      logic [2:0]        done_kind;
      logic signed [7:0] done_priority;
      logic              evicted;
      logic signed [7:0] evicted_priority;
      logic [2:0]        focus_now;
      logic [15:0]       switch_count;
      logic [3:0]        pending;
   } rsp_payload_type;

   typedef struct packed {
      logic       move;
      logic [2:0] focus;
   } focus_move_type;

   function automatic focus_move_type focus_for_kind(logic [2:0] kind, logic [2:0] tgt);
      focus_move_type res;
      res.move  = 1'b1;
      res.focus = FOCUS_NONE;
      case (kind)
         KIND_REHEARSAL:  res.focus = FOCUS_PHON;
         KIND_ENCODING:   res.focus = FOCUS_EPIS;
         KIND_RETRIEVAL:  res.focus = FOCUS_EPIS;
         KIND_INHIBITION: res.focus = FOCUS_DIV;
         KIND_SWITCHING: begin
            if (tgt inside {[FOCUS_PHON:FOCUS_EPIS]}) begin
               res.focus = tgt;
            end
         end
         default:         res.move = 1'b0;
      endcase
      return res;
   endfunction

endpackage

// ===== rtl/core/bptd_stream_if.sv =====
interface bptd_req_if;
   import bptd_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface bptd_rsp_if;
   import bptd_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/bptd_cell.sv =====
module bptd_cell
   import bptd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  chain_ctrl_type ctrl,
   input  entry_type      left_ent,
   input  logic           left_ge,
   input  entry_type      right_ent,
   output entry_type      ent,
   output logic           ge
);

   entry_type ent_ff;
   entry_type ent_in;

   assign ent = ent_ff;
   assign ge  = ent_ff.valid && (ent_ff.prio >= ctrl.item.prio);

   always_comb begin
      ent_in = ent_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (!ge) begin
               ent_in = left_ge ? ctrl.item : left_ent;
            end
         end
         OP_POP:    ent_in = right_ent;
         OP_EVICT: begin
            if (ent_ff.valid && (ent_ff.prio == ctrl.key)) begin
               ent_in = right_ent;
            end
         end
         OP_CLEAR:  ent_in.valid = 1'b0;
         default:   ent_in = ent_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff <= '0;
      end else begin
         ent_ff <= ent_in;
      end
   end

endmodule

// ===== rtl/core/bptd_chain.sv =====
module bptd_chain
   import bptd_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic              clock,
   input  logic              reset,
   input  chain_ctrl_type    ctrl,
   output entry_type         head_ent,
   output logic signed [7:0] tail_prio
);

   entry_type       ent_w [DEPTH];
   logic            ge_w [DEPTH];
   entry_type       left_w [DEPTH];
   logic            left_ge_w [DEPTH];
   entry_type       right_w [DEPTH];
   logic [DEPTH:0]  valid_vec;

   assign valid_vec[DEPTH] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign valid_vec[i] = ent_w[i].valid;
      if (i == 0) begin : g_first
         assign left_w[i]    = '0;
         assign left_ge_w[i] = 1'b1;
      end else begin : g_inner
         assign left_w[i]    = ent_w[i-1];
         assign left_ge_w[i] = ge_w[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_w[i] = '0;
      end else begin : g_mid
         assign right_w[i] = ent_w[i+1];
      end
      bptd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .left_ent  (left_w[i]),
         .left_ge   (left_ge_w[i]),
         .right_ent (right_w[i]),
         .ent       (ent_w[i]),
         .ge        (ge_w[i])
      );
   end

   assign head_ent = ent_w[0];

   // The last valid cell holds the lowest priority in the chain.
   always_comb begin
      tail_prio = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (valid_vec[i] && !valid_vec[i+1]) begin
            tail_prio = tail_prio | ent_w[i].prio;
         end
      end
   end

endmodule

// ===== rtl/core/bounded_priority_task_dispatcher_unit.sv =====
// An accepted transfer is registered and executed in ST_EXEC; a submit that evicts an
// entry also passes through ST_EVICT. ST_EMIT then registers the result, waiting while
// the previous result is not yet taken. No new transfer is accepted until the result is
// emitted; the sequencer steps the sorted cell chain at most once per item, once more to evict.
// Reset is synchronous: the chain is emptied, focus none, counters zero, limit 10, span 2000.
`include "bounded_priority_task_dispatcher_unit_defines.svh"

module bounded_priority_task_dispatcher_unit
   import bptd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   bptd_req_if.sink    req_chan,
   bptd_rsp_if.source  rsp_chan
);

   localparam int CW   = $clog2(QUEUE_DEPTH + 1);
   localparam int CMPW = (CW > 4) ? CW : 4;

   state_type        state_ff, state_in;
   req_payload_type  work_ff, work_in;
   rsp_payload_type  res_ff, res_in;
   rsp_payload_type  rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [2:0]       focus_ff, focus_in;
   logic [16:0]      age_ff, age_in;
   logic [15:0]      switch_ff, switch_in;
   logic [3:0]       limit_ff;
   logic [15:0]      span_ff;

   chain_ctrl_type    ctrl;
   entry_type         head_ent;
   logic signed [7:0] tail_prio;
   logic [CMPW-1:0]   lim_ext;
   logic [CMPW-1:0]   count_next_ext;
   logic [CMPW-1:0]   count_ext;
   logic [2:0]        cur_focus;
   logic              mv_en;
   logic [2:0]        mv_focus;
   focus_move_type    kind_move;

   bptd_chain #(.DEPTH(QUEUE_DEPTH)) u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .head_ent  (head_ent),
      .tail_prio (tail_prio)
   );

   assign count_ext      = CMPW'(count_ff);
   assign count_next_ext = count_ext + CMPW'(1);
   assign lim_ext        = (CMPW'(limit_ff) > CMPW'(QUEUE_DEPTH - 1)) ?
                           CMPW'(QUEUE_DEPTH - 1) : CMPW'(limit_ff);
   assign kind_move      = focus_for_kind(head_ent.kind, head_ent.tgt);

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   always_comb begin
      state_in       = state_ff;
      work_in        = work_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in    = rsp_data_ff;
      count_in       = count_ff;
      age_in         = age_ff;
      switch_in      = switch_ff;
      cur_focus      = focus_ff;
      mv_en          = 1'b0;
      mv_focus       = FOCUS_NONE;
      req_chan.ready = 1'b0;
      ctrl.op        = OP_HOLD;
      ctrl.item      = '0;
      ctrl.key       = tail_prio;

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               work_in  = req_chan.data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_in   = '0;
            state_in = ST_EMIT;
            case (work_ff.cmd)
               CMD_SUBMIT: begin
                  ctrl.op         = OP_INSERT;
                  ctrl.item.valid = 1'b1;
                  ctrl.item.kind  = work_ff.task_kind;
                  ctrl.item.prio  = work_ff.task_priority;
                  ctrl.item.tgt   = work_ff.target_focus;
                  count_in        = count_ff + CW'(1);
                  if (count_next_ext > lim_ext) begin
                     state_in = ST_EVICT;
                  end
               end
               CMD_PROCESS: begin
                  if (focus_ff != FOCUS_NONE && age_ff > {1'b0, span_ff}) begin
                     cur_focus = FOCUS_NONE;
                  end
                  if (count_ff != '0) begin
                     ctrl.op              = OP_POP;
                     count_in             = count_ff - CW'(1);
                     res_in.did_process   = 1'b1;
                     res_in.done_kind     = head_ent.kind;
                     res_in.done_priority = head_ent.prio;
                     mv_en                = kind_move.move;
                     mv_focus             = kind_move.focus;
                  end
               end
               CMD_TICK: begin
                  if (age_ff != AGE_MAX) begin
                     age_in = age_ff + 17'd1;
                  end
               end
               CMD_SET_FOCUS: begin
                  if (work_ff.target_focus <= FOCUS_DIV) begin
                     mv_en    = 1'b1;
                     mv_focus = work_ff.target_focus;
                  end
               end
               CMD_CLEAR_SWITCH: switch_in = '0;
               CMD_CLEAR_ALL: begin
                  ctrl.op   = OP_CLEAR;
                  count_in  = '0;
                  cur_focus = FOCUS_NONE;
                  age_in    = '0;
                  switch_in = '0;
               end
               default: state_in = ST_EMIT;
            endcase
         end
         ST_EVICT: begin
            ctrl.op                 = OP_EVICT;
            count_in                = count_ff - CW'(1);
            res_in.evicted          = 1'b1;
            res_in.evicted_priority = tail_prio;
            state_in                = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in              = res_ff;
               rsp_data_in.focus_now    = focus_ff;
               rsp_data_in.switch_count = switch_ff;
               rsp_data_in.pending      = count_ext[3:0];
               state_in                 = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      focus_in = cur_focus;
      if (mv_en && (mv_focus != cur_focus)) begin
         focus_in = mv_focus;
         age_in   = '0;
         if (switch_ff != SWITCH_MAX) begin
            switch_in = switch_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         focus_ff     <= FOCUS_NONE;
         age_ff       <= '0;
         switch_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         focus_ff     <= focus_in;
         age_ff       <= age_in;
         switch_ff    <= switch_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         span_ff  <= SPAN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TASK_LIMIT: limit_ff <= csr_wdata[3:0];
            CSR_FOCUS_SPAN: span_ff  <= csr_wdata;
            default:        span_ff  <= span_ff;
         endcase
      end
   end

   `BPTD_ASSERT_NOW(a_idle_count, clock, reset, state_ff == ST_IDLE, count_ff < CW'(QUEUE_DEPTH), "store count exceeds depth minus one at rest")
   `BPTD_ASSERT_NOW(a_head_count, clock, reset, 1'b1, head_ent.valid == (count_ff != '0), "chain head validity disagrees with count")
   `BPTD_ASSERT_NEXT(a_accept_exec, clock, reset, req_chan.valid && req_chan.ready, state_ff == ST_EXEC, "accepted transfer did not start execution")
   `BPTD_ASSERT_NOW(a_pop_or_evict, clock, reset, rsp_chan.valid, !(rsp_chan.data.did_process && rsp_chan.data.evicted), "result reports both a pop and an eviction")

endmodule

// ===== verif/testbench.sv =====
module testbench;
   import bptd_pkg::*;

   localparam int          STORE_DEPTH     = 16;
   localparam int unsigned CYCLE_LIMIT     = 3000000;
   localparam logic [2:0]  CMD_RESERVED_LO = 3'd6;
   localparam logic [2:0]  CMD_RESERVED_HI = 3'd7;
   localparam logic [2:0]  KIND_UNDEFINED  = 3'd7;
   localparam logic [2:0]  FOCUS_INVALID   = 3'd7;

   // Tracks the dispatcher state and the responses still owed by the block.
   class dispatch_scoreboard;
      bit [2:0]        slot_kind [STORE_DEPTH];
      bit signed [7:0] slot_prio [STORE_DEPTH];
      bit [2:0]        slot_tgt  [STORE_DEPTH];
      int unsigned     held;
      bit [2:0]        focus;
      bit [16:0]       age;
      bit [15:0]       switches;
      bit [3:0]        limit;
      bit [15:0]       span;
      rsp_payload_type awaited [$];
      int unsigned     errors;

      function new();
         held     = 0;
         focus    = FOCUS_NONE;
         age      = '0;
         switches = '0;
         limit    = LIMIT_RESET;
         span     = SPAN_RESET;
         errors   = 0;
      endfunction

      function void write_reg(logic index, logic [15:0] value);
         if (index == CSR_TASK_LIMIT) begin
            limit = value[3:0];
         end else begin
            span = value;
         end
      endfunction

      function int unsigned outstanding();
         return awaited.size();
      endfunction

      function void drop_slot(int unsigned idx);
         for (int unsigned i = idx; i + 1 < held; i++) begin
            slot_kind[i] = slot_kind[i + 1];
            slot_prio[i] = slot_prio[i + 1];
            slot_tgt[i]  = slot_tgt[i + 1];
         end
         held--;
      endfunction

      function void shift_focus(bit [2:0] next_focus);
         if (next_focus != focus) begin
            if (switches != SWITCH_MAX) begin
               switches++;
            end
            focus = next_focus;
            age   = '0;
         end
      endfunction

      function void note_transfer(req_payload_type item);
         rsp_payload_type exp;
         int unsigned     cap;
         int unsigned     at;
         bit [2:0]        popped_kind;
         bit [2:0]        popped_tgt;
         exp = '0;
         case (item.cmd)
            CMD_SUBMIT: begin
               cap = (limit > STORE_DEPTH - 1) ? STORE_DEPTH - 1 : limit;
               if (held < STORE_DEPTH) begin
                  slot_kind[held] = item.task_kind;
                  slot_prio[held] = item.task_priority;
                  slot_tgt[held]  = item.target_focus;
                  held++;
               end
               if (held > cap) begin
                  at = 0;
                  for (int unsigned i = 1; i < held; i++) begin
                     if (slot_prio[i] < slot_prio[at]) at = i;
                  end
                  exp.evicted          = 1'b1;
                  exp.evicted_priority = slot_prio[at];
                  drop_slot(at);
               end
            end
            CMD_PROCESS: begin
               if (focus != FOCUS_NONE && age > span) begin
                  focus = FOCUS_NONE;
               end
               if (held != 0) begin
                  at = 0;
                  for (int unsigned i = 1; i < held; i++) begin
                     if (slot_prio[i] > slot_prio[at]) at = i;
                  end
                  popped_kind       = slot_kind[at];
                  popped_tgt        = slot_tgt[at];
                  exp.did_process   = 1'b1;
                  exp.done_kind     = popped_kind;
                  exp.done_priority = slot_prio[at];
                  drop_slot(at);
                  case (popped_kind)
                     KIND_REHEARSAL: begin
                        shift_focus(FOCUS_PHON);
                     end
                     KIND_ENCODING, KIND_RETRIEVAL: begin
                        shift_focus(FOCUS_EPIS);
                     end
                     KIND_INHIBITION: begin
                        shift_focus(FOCUS_DIV);
                     end
                     KIND_SWITCHING: begin
                        if (popped_tgt >= FOCUS_PHON && popped_tgt <= FOCUS_EPIS) begin
                           shift_focus(popped_tgt);
                        end else begin
                           shift_focus(FOCUS_NONE);
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            CMD_TICK: begin
               if (age != AGE_MAX) age++;
            end
            CMD_SET_FOCUS: begin
               if (item.target_focus <= FOCUS_DIV) shift_focus(item.target_focus);
            end
            CMD_CLEAR_SWITCH: begin
               switches = '0;
            end
            CMD_CLEAR_ALL: begin
               held     = 0;
               focus    = FOCUS_NONE;
               age      = '0;
               switches = '0;
            end
            default: begin
            end
         endcase
         exp.focus_now    = focus;
         exp.switch_count = switches;
         exp.pending      = 4'(held);
         awaited          = {awaited, exp};
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type exp;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response: got %p", got);
            return;
         end
         exp = awaited.pop_front();
         if (got.did_process !== exp.did_process || got.done_kind !== exp.done_kind ||
             got.done_priority !== exp.done_priority || got.evicted !== exp.evicted ||
             got.evicted_priority !== exp.evicted_priority ||
             got.focus_now !== exp.focus_now || got.switch_count !== exp.switch_count ||
             got.pending !== exp.pending) begin
            errors++;
            if (errors <= 10) $display("response mismatch: expected %p, got %p", exp, got);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;
   bit          req_idle;
   bit          rsp_idle;
   int unsigned cycle_count;

   bptd_req_if req_chan();
   bptd_rsp_if rsp_chan();

   dispatch_scoreboard sb;

   bounded_priority_task_dispatcher_unit #(.QUEUE_DEPTH(STORE_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic req_payload_type make_item(logic [2:0] cmd, logic [2:0] kind,
                                                 logic signed [7:0] prio, logic [2:0] tgt);
      req_payload_type item;
      item.cmd           = cmd;
      item.task_kind     = kind;
      item.task_priority = prio;
      item.target_focus  = tgt;
      return item;
   endfunction

   function automatic req_payload_type random_item();
      req_payload_type item;
      int unsigned     pick;
      pick               = $urandom_range(99);
      item.task_kind     = ($urandom_range(9) == 0) ? 3'($urandom_range(7))
                                                    : 3'($urandom_range(4));
      item.task_priority = ($urandom_range(1) == 0) ? 8'($urandom)
                                                    : 8'($urandom_range(4) - 2);
      item.target_focus  = 3'($urandom_range(7));
      if (pick < 40) begin
         item.cmd = CMD_SUBMIT;
      end else if (pick < 70) begin
         item.cmd = CMD_PROCESS;
      end else if (pick < 85) begin
         item.cmd = CMD_TICK;
      end else if (pick < 93) begin
         item.cmd = CMD_SET_FOCUS;
      end else if (pick < 96) begin
         item.cmd = CMD_CLEAR_SWITCH;
      end else if (pick < 98) begin
         item.cmd = CMD_CLEAR_ALL;
      end else begin
         item.cmd = $urandom_range(1) ? CMD_RESERVED_LO : CMD_RESERVED_HI;
      end
      return item;
   endfunction

   function automatic req_payload_type random_submit();
      req_payload_type item;
      item     = random_item();
      item.cmd = CMD_SUBMIT;
      return item;
   endfunction

   task automatic send_item(input req_payload_type item);
      while (req_idle && $urandom_range(99) < 34) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= item;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sb.note_transfer(item);
   endtask

   task automatic send_random(input int unsigned count);
      for (int unsigned n = 0; n < count; n++) begin
         send_item(random_item());
      end
   endtask

   // Registers change only once every owed response has come back.
   task automatic program_regs(input logic [3:0] limit_val, input logic [15:0] span_val);
      logic [15:0] limit_word;
      limit_word     = {12'($urandom), limit_val};
      req_chan.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_TASK_LIMIT;
      csr_wdata <= limit_word;
      @(posedge clock);
      sb.write_reg(CSR_TASK_LIMIT, limit_word);
      csr_index <= CSR_FOCUS_SPAN;
      csr_wdata <= span_val;
      @(posedge clock);
      sb.write_reg(CSR_FOCUS_SPAN, span_val);
      csr_we <= 1'b0;
   endtask

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            sb.check_result(rsp_chan.data);
         end
         rsp_chan.ready <= !(rsp_idle && $urandom_range(99) < 34);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("bounded_priority_task_dispatcher_unit verification failed");
      $finish;
   end

   initial begin
      sb             = new();
      req_idle       = 1'b1;
      rsp_idle       = 1'b1;
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.data  <= '0;
      csr_we         <= 1'b0;
      csr_index      <= CSR_TASK_LIMIT;
      csr_wdata      <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(make_item(CMD_PROCESS, KIND_REHEARSAL, 8'sd0, FOCUS_NONE));
      send_item(make_item(CMD_SUBMIT, KIND_REHEARSAL, 8'sd127, FOCUS_NONE));
      send_item(make_item(CMD_SUBMIT, KIND_ENCODING, 8'sh80, FOCUS_DIV));
      send_item(make_item(CMD_SUBMIT, KIND_RETRIEVAL, 8'sd0, FOCUS_PHON));
      send_item(make_item(CMD_SUBMIT, KIND_INHIBITION, 8'sd5, FOCUS_EPIS));
      send_item(make_item(CMD_SUBMIT, KIND_SWITCHING, 8'sd5, FOCUS_VISU));
      send_item(make_item(CMD_SUBMIT, KIND_SWITCHING, 8'sd5, FOCUS_DIV));
      send_item(make_item(CMD_SUBMIT, KIND_UNDEFINED, -8'sd1, FOCUS_INVALID));
      repeat (7) send_item(make_item(CMD_PROCESS, KIND_UNDEFINED, -8'sd1, FOCUS_INVALID));
      send_item(make_item(CMD_SET_FOCUS, KIND_REHEARSAL, 8'sd0, FOCUS_DIV));
      send_item(make_item(CMD_SET_FOCUS, KIND_REHEARSAL, 8'sd0, FOCUS_INVALID));
      send_item(make_item(CMD_TICK, KIND_REHEARSAL, 8'sd0, FOCUS_NONE));
      send_item(make_item(CMD_CLEAR_SWITCH, KIND_REHEARSAL, 8'sd0, FOCUS_NONE));
      send_item(make_item(CMD_RESERVED_LO, KIND_REHEARSAL, 8'sd0, FOCUS_NONE));
      send_item(make_item(CMD_RESERVED_HI, KIND_UNDEFINED, -8'sd1, FOCUS_INVALID));
      send_item(make_item(CMD_CLEAR_ALL, KIND_REHEARSAL, 8'sd0, FOCUS_NONE));

      // A focus whose age equals the span survives; one more tick expires it.
      program_regs(4'd10, 16'd2);
      send_item(make_item(CMD_SET_FOCUS, KIND_REHEARSAL, 8'sd0, FOCUS_EPIS));
      repeat (2) send_item(make_item(CMD_TICK, KIND_REHEARSAL, 8'sd0, FOCUS_NONE));
      send_item(make_item(CMD_PROCESS, KIND_REHEARSAL, 8'sd0, FOCUS_NONE));
      send_item(make_item(CMD_TICK, KIND_REHEARSAL, 8'sd0, FOCUS_NONE));
      send_item(make_item(CMD_PROCESS, KIND_REHEARSAL, 8'sd0, FOCUS_NONE));
      send_random(200);

      program_regs(4'd0, 16'd0);
      send_random(60);

      req_idle = 1'b0;
      rsp_idle = 1'b0;
      program_regs(4'd15, 16'hFFFF);
      send_random(200);
      send_item(make_item(CMD_CLEAR_ALL, KIND_REHEARSAL, 8'sd0, FOCUS_NONE));
      repeat (15) send_item(random_submit());
      req_idle = 1'b1;
      rsp_idle = 1'b1;

      // The store is full when the limit drops; each submit still evicts only one.
      program_regs(4'd2, 16'd5);
      send_random(200);

      program_regs(4'd1, 16'd1);
      send_random(100);

      program_regs(4'd7, 16'd40);
      send_random(200);

      req_idle = 1'b0;
      rsp_idle = 1'b0;
      program_regs(4'd10, 16'hFFFF);
      send_item(make_item(CMD_CLEAR_ALL, KIND_REHEARSAL, 8'sd0, FOCUS_NONE));
      send_item(make_item(CMD_SET_FOCUS, KIND_REHEARSAL, 8'sd0, FOCUS_PHON));
      for (int unsigned n = 0; n < 30; n++) begin
         send_item(make_item(CMD_TICK, KIND_REHEARSAL, 8'sd0, FOCUS_NONE));
      end
      send_item(make_item(CMD_PROCESS, KIND_REHEARSAL, 8'sd0, FOCUS_NONE));
      for (int unsigned n = 0; n < 30; n++) begin
         send_item(make_item(CMD_SET_FOCUS, KIND_REHEARSAL, 8'sd0,
                             n[0] ? FOCUS_VISU : FOCUS_PHON));
      end
      send_item(make_item(CMD_CLEAR_SWITCH, KIND_REHEARSAL, 8'sd0, FOCUS_NONE));
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      send_random(40);

      req_chan.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("bounded_priority_task_dispatcher_unit verification clean");
      end else begin
         $display("bounded_priority_task_dispatcher_unit verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bptd_pkg.sv
rtl/core/bptd_stream_if.sv
rtl/core/bptd_cell.sv
rtl/core/bptd_chain.sv
rtl/core/bounded_priority_task_dispatcher_unit.sv
verif/testbench.sv
